FILE: src/vaos_pkg.sv
package vaos_pkg;

  localparam int NUM_VOICES_DEF = 16;
  localparam int VLIM_W         = 5;
  localparam int VSEL_W         = 4;
  localparam int VIDX_W         = 4;
  localparam int STAMP_W        = 32;

  localparam logic [VLIM_W-1:0] VLIM_RST = 5'd8;

  localparam logic FUNC_ALLOC  = 1'b0;
  localparam logic FUNC_STATUS = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } vaos_state_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic status_wr;
    logic commit;
  } vaos_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_busy;
  } vaos_sts_t;

endpackage

FILE: src/vaos_in_if.sv
interface vaos_in_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [vaos_pkg::VSEL_W-1:0] voice_sel;
  logic                        is_active;
  logic                        is_releasing;
  logic                        is_pending;

  modport source (output valid, func, voice_sel, is_active, is_releasing, is_pending,
                  input ready);
  modport sink (input valid, func, voice_sel, is_active, is_releasing, is_pending,
                output ready);
endinterface

FILE: src/vaos_out_if.sv
interface vaos_out_if;
  logic                        valid;
  logic                        ready;
  logic [vaos_pkg::VIDX_W-1:0] voice_index;
  logic                        steal;

  modport source (output valid, voice_index, steal, input ready);
  modport sink (input valid, voice_index, steal, output ready);
endinterface

FILE: src/vaos_ctrl.sv
module vaos_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_func,
  output logic               in_ready,
  input  vaos_pkg::vaos_sts_t sts,
  output vaos_pkg::vaos_cmd_t cmd
);

  vaos_pkg::vaos_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vaos_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      vaos_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_func == vaos_pkg::FUNC_ALLOC) begin
            cmd.start = 1'b1;
            state_nxt = vaos_pkg::ST_SCAN;
          end else begin
            cmd.status_wr = 1'b1;
          end
        end
      end
      vaos_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = vaos_pkg::ST_DRAIN;
        end
      end
      vaos_pkg::ST_DRAIN: begin
        // last stamp read is compared on this edge
        state_nxt = vaos_pkg::ST_COMMIT;
      end
      vaos_pkg::ST_COMMIT: begin
        // hold until the output register is free
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = vaos_pkg::ST_IDLE;
        end
      end
      default: state_nxt = vaos_pkg::ST_IDLE;
    endcase
  end

endmodule

FILE: src/vaos_dp.sv
module vaos_dp #(
  parameter int NUM_VOICES = vaos_pkg::NUM_VOICES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [vaos_pkg::VLIM_W-1:0]  cfg_wdata,
  input  logic [vaos_pkg::VSEL_W-1:0]  in_voice_sel,
  input  logic                         in_is_active,
  input  logic                         in_is_releasing,
  input  logic                         in_is_pending,
  input  vaos_pkg::vaos_cmd_t          cmd,
  output vaos_pkg::vaos_sts_t          sts,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [vaos_pkg::VIDX_W-1:0]  out_voice_index,
  output logic                         out_steal
);

  localparam int IW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int CW = $clog2(NUM_VOICES + 1);
  localparam int LW = (CW > vaos_pkg::VLIM_W) ? CW : vaos_pkg::VLIM_W;
  localparam int SW = vaos_pkg::STAMP_W;

  logic [vaos_pkg::VLIM_W-1:0] vlim_r;
  logic [NUM_VOICES-1:0]       active_r, releasing_r, pending_r, stamp_vld_r;
  logic [SW-1:0]               stamp_mem [NUM_VOICES];
  logic [SW-1:0]               stamp_cnt_r, stamp_nxt;

  logic [IW-1:0] idx_r, last_r, cmp_idx_r;
  logic          cmp_vld_r;
  logic [SW-1:0] rd_data_r;
  logic          rd_vld_r;

  logic          free_found_r, rel_found_r, any_found_r;
  logic [IW-1:0] free_idx_r, rel_idx_r, any_idx_r;
  logic [SW-1:0] rel_stamp_r, any_stamp_r;

  logic [LW-1:0] lim_ext, lim_eff;
  logic [IW-1:0] last_eff, sel_idx, pick;
  logic          pick_steal;
  logic [SW-1:0] cur_stamp;
  logic          cur_act, cur_rel, cur_pend;
  logic          free_hit, rel_hit, any_hit;
  logic          out_valid_r, out_steal_r;
  logic [vaos_pkg::VIDX_W-1:0] out_idx_r;

  // clamp the voice limit into 1..NUM_VOICES
  always_comb begin
    lim_ext = LW'(vlim_r);
    if (lim_ext == '0) begin
      lim_eff = LW'(1);
    end else if (lim_ext > LW'(NUM_VOICES)) begin
      lim_eff = LW'(NUM_VOICES);
    end else begin
      lim_eff = lim_ext;
    end
    last_eff = IW'(lim_eff - LW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlim_r <= vaos_pkg::VLIM_RST;
    end else if (cfg_we) begin
      vlim_r <= cfg_wdata;
    end
  end

  // scan address and read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.scan;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      idx_r  <= '0;
      last_r <= last_eff;
    end else if (cmd.scan) begin
      idx_r <= idx_r + IW'(1);
    end
    rd_data_r <= stamp_mem[idx_r];
    rd_vld_r  <= stamp_vld_r[idx_r];
    cmp_idx_r <= idx_r;
  end

  assign sts.scan_last = (idx_r == last_r);
  assign sts.out_busy  = out_valid_r && !out_ready;

  // compare stage
  always_comb begin
    cur_stamp = rd_vld_r ? rd_data_r : '0;
    cur_act   = active_r[cmp_idx_r];
    cur_rel   = releasing_r[cmp_idx_r];
    cur_pend  = pending_r[cmp_idx_r];
    free_hit  = cmp_vld_r && !cur_act && !cur_pend;
    rel_hit   = cmp_vld_r && cur_act && cur_rel && !cur_pend;
    any_hit   = cmp_vld_r && !cur_pend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.start) begin
      free_found_r <= 1'b0;
      rel_found_r  <= 1'b0;
      any_found_r  <= 1'b0;
    end else begin
      if (free_hit && !free_found_r) begin
        free_found_r <= 1'b1;
      end
      // strict compare keeps the lowest index on equal stamps
      if (rel_hit && (!rel_found_r || cur_stamp < rel_stamp_r)) begin
        rel_found_r <= 1'b1;
      end
      if (any_hit && (!any_found_r || cur_stamp < any_stamp_r)) begin
        any_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (free_hit && !free_found_r) begin
      free_idx_r <= cmp_idx_r;
    end
    if (rel_hit && (!rel_found_r || cur_stamp < rel_stamp_r)) begin
      rel_idx_r   <= cmp_idx_r;
      rel_stamp_r <= cur_stamp;
    end
    if (any_hit && (!any_found_r || cur_stamp < any_stamp_r)) begin
      any_idx_r   <= cmp_idx_r;
      any_stamp_r <= cur_stamp;
    end
  end

  always_comb begin
    priority if (free_found_r) begin
      pick       = free_idx_r;
      pick_steal = 1'b0;
    end else if (rel_found_r) begin
      pick       = rel_idx_r;
      pick_steal = 1'b1;
    end else if (any_found_r) begin
      pick       = any_idx_r;
      pick_steal = 1'b1;
    end else begin
      pick       = '0;
      pick_steal = 1'b1;
    end
  end

  assign stamp_nxt = stamp_cnt_r + SW'(1);
  assign sel_idx   = IW'(in_voice_sel);

  // voice flags, stamp valid bits and counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      releasing_r <= '0;
      pending_r   <= '0;
      stamp_vld_r <= '0;
      stamp_cnt_r <= '0;
    end else if (cmd.commit) begin
      stamp_cnt_r        <= stamp_nxt;
      stamp_vld_r[pick]  <= 1'b1;
      if (pick_steal) begin
        pending_r[pick] <= 1'b1;
      end else begin
        active_r[pick]    <= 1'b1;
        releasing_r[pick] <= 1'b0;
      end
    end else if (cmd.status_wr && (32'(in_voice_sel) < NUM_VOICES)) begin
      active_r[sel_idx]    <= in_is_active;
      releasing_r[sel_idx] <= in_is_releasing;
      pending_r[sel_idx]   <= in_is_pending;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      stamp_mem[pick] <= stamp_nxt;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_idx_r   <= vaos_pkg::VIDX_W'(pick);
      out_steal_r <= pick_steal;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_voice_index = out_idx_r;
  assign out_steal       = out_steal_r;

endmodule

FILE: src/voice_allocator_oldest_steal_unit.sv
// Allocate word: scans voices 0..N-1, N = clamped voice limit;
// the stamp memory is scanned one voice per cycle through a registered read.
// The input takes no new word until an allocate commits; while idle, a status word is taken every cycle.
// A result that is not taken holds the next allocate in its commit step.
// Reset (rst_n low, synchronous): all marks, stamps and the stamp counter clear,
// voice limit returns to 8, no result pending.
module voice_allocator_oldest_steal_unit #(
  parameter int NUM_VOICES = vaos_pkg::NUM_VOICES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [vaos_pkg::VLIM_W-1:0] cfg_wdata,
  vaos_in_if.sink                     in_chan,
  vaos_out_if.source                  out_chan
);

  vaos_pkg::vaos_cmd_t cmd;
  vaos_pkg::vaos_sts_t sts;

  vaos_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_func  (in_chan.func),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  vaos_dp #(
    .NUM_VOICES (NUM_VOICES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_voice_sel    (in_chan.voice_sel),
    .in_is_active    (in_chan.is_active),
    .in_is_releasing (in_chan.is_releasing),
    .in_is_pending   (in_chan.is_pending),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_voice_index (out_chan.voice_index),
    .out_steal       (out_chan.steal)
  );

endmodule

FILE: src/vaos_checker.sv
module vaos_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_func,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [vaos_pkg::VIDX_W-1:0] out_voice_index,
  input logic                        out_steal
);

  // a waiting result word holds its place and contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_voice_index) && $stable(out_steal))
    else $error("result word dropped or changed while stalled");

  // an allocate blocks the input while the voices are scanned
  a_alloc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == vaos_pkg::FUNC_ALLOC) |=> !in_ready)
    else $error("input taken during an allocate");

  // a status word yields no result and keeps the input open
  a_status_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == vaos_pkg::FUNC_STATUS)
    |=> in_ready && !$rose(out_valid))
    else $error("status word produced a result or stalled input");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind voice_allocator_oldest_steal_unit vaos_checker u_vaos_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .in_func         (in_chan.func),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_voice_index (out_chan.voice_index),
  .out_steal       (out_chan.steal)
);
